[rtl/park_miller_ranged_random_assert.svh]
// assertion macros for the ranged random generator
// used by every rtl file that carries concurrent checks, needs no package
`ifndef PARK_MILLER_RANGED_RANDOM_ASSERT_SVH
`define PARK_MILLER_RANGED_RANDOM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// general property, checked on every rising edge outside reset
`define PMR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pmr property violated");
// condition that must never be seen outside reset
`define PMR_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pmr forbidden condition seen");
`else
`define PMR_ASSERT(lbl, clk, rst_n, prop)
`define PMR_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/pmr_pkg.sv]
// shared types and constants of the ranged random generator
// no dependencies
package pmr_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STATE_W = 31;
  localparam int unsigned MUL_W   = 15;
  localparam int unsigned PROD_W  = DATA_W + MUL_W;
  localparam int unsigned DVD_W   = 36;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ITER_W  = 6;

  localparam logic [MUL_W-1:0]   MUL_G        = 15'd16807;
  localparam logic [STATE_W-1:0] MOD_N        = 31'h7fffffff;
  localparam logic [DATA_W-1:0]  ZERO_SUB     = 32'd20080806;
  localparam logic [DATA_W-1:0]  SEED_RESET   = 32'h20080806;
  localparam logic [DATA_W-1:0]  FULL_SPAN    = 32'hffffffff;
  localparam logic [DATA_W-1:0]  EXACT_SPAN   = 32'h7ffffffe;
  localparam logic [DATA_W-1:0]  NARROW_LIMIT = 32'h07ffffff;
  localparam logic [CNT_W-1:0]   POOL_FILL    = 5'd30;
  localparam logic [CNT_W-1:0]   FULL_NEED    = 5'd2;
  localparam logic [CNT_W-1:0]   WIDE_NEED    = 5'd6;
  localparam logic [ITER_W-1:0]  DIV_ITERS    = 6'd36;

  typedef enum logic [1:0] {
    MODE_FULL   = 2'd0,
    MODE_EXACT  = 2'd1,
    MODE_NARROW = 2'd2,
    MODE_WIDE   = 2'd3
  } pmr_mode_t;

endpackage

[rtl/pmr_if.sv]
// request and response channel interfaces of the ranged random generator
// depends on pmr_pkg
interface pmr_req_if;
  import pmr_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] range_first;
  logic [DATA_W-1:0] range_last;

  modport source (output valid, output range_first, output range_last, input ready);
  modport sink   (input valid, input range_first, input range_last, output ready);
endinterface

interface pmr_rsp_if;
  import pmr_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/park_miller_ranged_random.sv]
// top level of the ranged random generator: sequencer, bit pool, output stage
// depends on pmr_pkg, pmr_if, pmr_modmul, pmr_remdiv and the assertion header
//
// usage:
// - in_req carries one request per transfer (range_first, range_last,
//   inclusive); out_rsp returns exactly one value per request, in order
// - cfg_we with cfg_wdata reloads the generator state and empties the bit
//   pool; write only while no request is in flight
// - one request at a time: ready stays low from the request transfer until
//   the result has been loaded into the output register
// - each request makes a multiplier pass for its draw; the full and wide spans
//   make a second pass, a refill draw, when the pool runs short, and all spans
//   but the full and exact ones then go through the remainder unit (36-step
//   serial divider); the worst case is set by two passes through the
//   two-stage modular multiplier plus the bit-serial remainder unit
// - the result waits in the output register while the receiver stalls; the
//   next request is still taken and worked on, and its result is held back
//   until the pending one has been transferred
// - reset loads the generator with 0x20080806, empties the pool and drops
//   out_rsp.valid
`include "park_miller_ranged_random_assert.svh"

module park_miller_ranged_random (
  input  logic                       clk,
  input  logic                       rst_n,
  pmr_req_if.sink                    in_req,
  pmr_rsp_if.source                  out_rsp,
  input  logic                       cfg_we,
  input  logic [pmr_pkg::DATA_W-1:0] cfg_wdata
);
  import pmr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DRAW   = 8'b0000_0010,
    S_DRAW_W = 8'b0000_0100,
    S_FILL   = 8'b0000_1000,
    S_FILL_W = 8'b0001_0000,
    S_MIX    = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } pmr_state_t;

  pmr_state_t state_r, state_nxt;

  // generator and bit pool
  logic [DATA_W-1:0]  gen_r, gen_nxt;
  logic [STATE_W-1:0] pool_r, pool_nxt;
  logic [CNT_W-1:0]   pool_cnt_r, pool_cnt_nxt;

  // per-request working registers
  logic [DATA_W-1:0]  first_r;
  logic [DATA_W-1:0]  span_r;
  pmr_mode_t          mode_r;
  logic [STATE_W-1:0] draw_r, draw_nxt;
  logic [DATA_W-1:0]  off_r, off_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_value_r;

  // shared units
  logic               mm_start;
  logic [DATA_W-1:0]  mm_x;
  logic               mm_done;
  logic [STATE_W-1:0] mm_res;
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic               div_done;
  logic [DATA_W-1:0]  div_rem;

  logic               in_xfer;
  logic               out_xfer;
  logic               out_free;
  logic [DATA_W-1:0]  span_in;
  logic               need_fill;

  assign in_xfer  = in_req.valid && in_req.ready;
  assign out_xfer = out_valid_r && out_rsp.ready;
  assign out_free = !out_valid_r || out_rsp.ready;
  assign span_in  = in_req.range_last - in_req.range_first;

  // zero state is replaced before the multiply
  assign mm_x = (gen_r == '0) ? ZERO_SUB : gen_r;

  // refill decision is made on the pool count before this request uses it
  assign need_fill = ((mode_r == MODE_FULL) && (pool_cnt_r < FULL_NEED)) ||
                     ((mode_r == MODE_WIDE) && (pool_cnt_r < WIDE_NEED));

  pmr_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .x     (mm_x),
    .done  (mm_done),
    .res   (mm_res)
  );

  pmr_remdiv u_remdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (span_r + DATA_W'(1)),
    .done     (div_done),
    .rem      (div_rem)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    pool_nxt      = pool_r;
    pool_cnt_nxt  = pool_cnt_r;
    draw_nxt      = draw_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    mm_start      = 1'b0;
    div_start     = 1'b0;
    div_dividend  = {{(DVD_W-STATE_W+1){1'b0}}, draw_r[STATE_W-1:1]};

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        mm_start  = 1'b1;
        state_nxt = S_DRAW_W;
      end
      S_DRAW_W: begin
        if (mm_done) begin
          gen_nxt   = {1'b0, mm_res};
          draw_nxt  = mm_res;
          state_nxt = need_fill ? S_FILL : S_MIX;
        end
      end
      S_FILL: begin
        mm_start  = 1'b1;
        state_nxt = S_FILL_W;
      end
      S_FILL_W: begin
        if (mm_done) begin
          gen_nxt      = {1'b0, mm_res};
          pool_nxt     = mm_res;
          pool_cnt_nxt = POOL_FILL;
          state_nxt    = S_MIX;
        end
      end
      S_MIX: begin
        case (mode_r)
          MODE_FULL: begin
            off_nxt      = {pool_r[1:0], draw_r[STATE_W-1:1]};
            pool_nxt     = pool_r >> 2;
            pool_cnt_nxt = pool_cnt_r - FULL_NEED;
            state_nxt    = S_OUT;
          end
          MODE_EXACT: begin
            off_nxt   = {1'b0, draw_r};
            state_nxt = S_OUT;
          end
          MODE_WIDE: begin
            div_dividend = {pool_r[5:0], draw_r[STATE_W-1:1]};
            div_start    = 1'b1;
            pool_nxt     = pool_r >> 6;
            pool_cnt_nxt = pool_cnt_r - WIDE_NEED;
            state_nxt    = S_DIV;
          end
          default: begin
            // narrow span: dividend is the shifted draw alone
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          off_nxt   = div_rem;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold here while an earlier result still waits for its transfer
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // seed write reloads state and empties the pool
    if (cfg_we) begin
      gen_nxt      = cfg_wdata;
      pool_nxt     = '0;
      pool_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_r       <= SEED_RESET;
      pool_r      <= '0;
      pool_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      pool_r      <= pool_nxt;
      pool_cnt_r  <= pool_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    draw_r <= draw_nxt;
    off_r  <= off_nxt;
    if (in_xfer) begin
      first_r <= in_req.range_first;
      span_r  <= span_in;
      if (span_in == FULL_SPAN) begin
        mode_r <= MODE_FULL;
      end else if (span_in == EXACT_SPAN) begin
        mode_r <= MODE_EXACT;
      end else if (span_in < NARROW_LIMIT) begin
        mode_r <= MODE_NARROW;
      end else begin
        mode_r <= MODE_WIDE;
      end
    end
    if ((state_r == S_OUT) && out_free) begin
      out_value_r <= off_r + first_r;
    end
  end

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.value = out_value_r;

  `PMR_ASSERT(a_busy_after_accept, clk, rst_n, in_xfer |=> !in_req.ready)
  `PMR_NEVER(a_pool_count_even, clk, rst_n, pool_cnt_r[0] || pool_cnt_r > POOL_FILL)
  `PMR_NEVER(a_full_pool_short, clk, rst_n,
    state_r == S_MIX && mode_r == MODE_FULL && pool_cnt_r < FULL_NEED)
  `PMR_NEVER(a_wide_pool_short, clk, rst_n,
    state_r == S_MIX && mode_r == MODE_WIDE && pool_cnt_r < WIDE_NEED)

endmodule

[rtl/pmr_modmul.sv]
// two-stage multiply by 16807 modulo 2^31-1 with mersenne folding
// depends on pmr_pkg and the assertion header
`include "park_miller_ranged_random_assert.svh"

module pmr_modmul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pmr_pkg::DATA_W-1:0]  x,
  output logic                        done,
  output logic [pmr_pkg::STATE_W-1:0] res
);
  import pmr_pkg::*;

  logic [PROD_W-1:0]  prod_r;
  logic               v1_r;
  logic               done_r;
  logic [STATE_W-1:0] res_r;

  logic [DATA_W-1:0]  fold1;
  logic [DATA_W-1:0]  fold2;
  logic [STATE_W-1:0] res_nxt;

  // fold high bits onto low bits twice, then one conditional subtract
  always_comb begin
    fold1 = {1'b0, prod_r[STATE_W-1:0]} + {{(DATA_W-(PROD_W-STATE_W)){1'b0}},
                                           prod_r[PROD_W-1:STATE_W]};
    fold2 = {1'b0, fold1[STATE_W-1:0]} + {{(DATA_W-1){1'b0}}, fold1[DATA_W-1]};
    if (fold2 >= {1'b0, MOD_N}) begin
      res_nxt = STATE_W'(fold2 - {1'b0, MOD_N});
    end else begin
      res_nxt = fold2[STATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
    prod_r <= {{(PROD_W-DATA_W){1'b0}}, x} * {{(PROD_W-MUL_W){1'b0}}, MUL_G};
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

  `PMR_NEVER(a_res_below_mod, clk, rst_n, done_r && res_r == MOD_N)
  `PMR_ASSERT(a_done_follows, clk, rst_n, start |=> ##1 done_r)
  `PMR_NEVER(a_done_needs_start, clk, rst_n, done_r && !$past(start, 2))

endmodule

[rtl/pmr_remdiv.sv]
// bit-serial restoring remainder of a 36-bit dividend by a 32-bit divisor
// depends on pmr_pkg and the assertion header
`include "park_miller_ranged_random_assert.svh"

module pmr_remdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pmr_pkg::DVD_W-1:0]  dividend,
  input  logic [pmr_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pmr_pkg::DATA_W-1:0] rem
);
  import pmr_pkg::*;

  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              done_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DATA_W-1:0] dsr_r;
  logic [DATA_W-1:0] rem_r, rem_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  // one quotient bit per cycle: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    cnt_nxt = cnt_r - ITER_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= DIV_ITERS;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_nxt;
      done_r <= (cnt_nxt == '0);
    end else begin
      done_r <= 1'b0;
    end
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `PMR_NEVER(a_rem_below_divisor, clk, rst_n, done_r && rem_r >= dsr_r)
  `PMR_NEVER(a_done_when_idle, clk, rst_n, done_r && cnt_r != '0)
  `PMR_ASSERT(a_start_loads, clk, rst_n, start |=> cnt_r == DIV_ITERS)

endmodule
